// ===== rtl/dons_pkg.sv =====
package dons_pkg;

    localparam int DATA_W       = 32;
    localparam int RATE_W       = 31;
    localparam int DECAY_W      = 17;
    localparam int NODE_INDEX_W = 10;
    localparam int CFG_INDEX_W  = 3;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = 2;
    localparam int BACK_STAGES  = 15;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DAMPING_RATE     = 3'd0,
        REG_STEP_LENGTH      = 3'd1,
        REG_INVERSE_STEP     = 3'd2,
        REG_TWO_OVER_DAMPING = 3'd3,
        REG_DECAY_FACTOR     = 3'd4,
        REG_INITIAL_LEVEL    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [RATE_W-1:0]  damping_rate;
        logic [RATE_W-1:0]  step_length;
        logic [RATE_W-1:0]  inverse_step;
        logic [RATE_W-1:0]  two_over_damping;
        logic [DECAY_W-1:0] decay_factor;
    } osc_cfg_t;

    localparam osc_cfg_t CFG_RESET = '{
        damping_rate:     31'd65536,
        step_length:      31'd65536,
        inverse_step:     31'd65536,
        two_over_damping: 31'd131072,
        decay_factor:     17'd24109
    };

    localparam logic signed [DATA_W-1:0] LEVEL_RESET = 32'sd0;

    typedef struct packed {
        logic [NODE_INDEX_W-1:0]  node_index;
        logic signed [DATA_W-1:0] drive_sample;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] last_drive;
        logic signed [DATA_W-1:0] last_phi;
        logic signed [DATA_W-1:0] phi_rate;
    } node_state_t;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        if (v > SAT_HI) begin
            return 32'sh7fffffff;
        end
        else if (v < SAT_LO) begin
            return 32'sh80000000;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] add_s(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat32(s);
    endfunction

    function automatic logic signed [DATA_W-1:0] sub_s(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return sat32(s);
    endfunction

    // floor of product / 2^fb, then saturate
    function automatic logic signed [DATA_W-1:0] fx_scale(input logic signed [63:0] p,
                                                          input int unsigned fb);
        logic signed [63:0] s;
        s = p >>> fb;
        return sat32(s);
    endfunction

endpackage

// ===== rtl/dons_if.sv =====
interface dons_in_if import dons_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [NODE_INDEX_W-1:0]  node_index;
    logic signed [DATA_W-1:0] drive_sample;

    modport source (output valid, output node_index, output drive_sample, input ready);
    modport sink (input valid, input node_index, input drive_sample, output ready);
endinterface

interface dons_out_if import dons_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [NODE_INDEX_W-1:0]  node_out;
    logic signed [DATA_W-1:0] phi_out;

    modport source (output valid, output node_out, output phi_out, input ready);
    modport sink (input valid, input node_out, input phi_out, output ready);
endinterface

// ===== rtl/dons_ram.sv =====
module dons_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/dons_front.sv =====
module dons_front import dons_pkg::*; #(
    parameter int NODE_COUNT = 1024,
    parameter int KEY_W = 10,
    parameter int HAZ_N = 19
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dons_in_if.sink                     in_ch,
    input  logic                        hold,
    input  logic [HAZ_N-1:0]            busy_valid,
    input  logic [HAZ_N-1:0][KEY_W-1:0] busy_key,
    input  logic                        queue_full,
    output logic                        push,
    output item_t                       push_item,
    output logic [KEY_W-1:0]            push_key
);

    logic             f_valid_reg;
    item_t            f_item_reg;
    logic [KEY_W-1:0] f_key;
    logic             hit;
    logic             take;

    assign take = in_ch.valid && in_ch.ready;

    // node index folded onto the state memory
    if (NODE_COUNT >= (1 << NODE_INDEX_W))
    begin : g_key_direct
        assign f_key = KEY_W'(f_item_reg.node_index);
    end
    else
    begin : g_key_fold
        localparam int LOG_N = $clog2(NODE_COUNT);
        localparam int SHIFT = NODE_INDEX_W + LOG_N;
        localparam int MUL_W = SHIFT + 1;
        localparam int QP_W = NODE_INDEX_W + MUL_W;
        localparam int BP_W = NODE_INDEX_W + KEY_W + 1;
        localparam logic [MUL_W-1:0] MUL =
            MUL_W'(((1 << SHIFT) + NODE_COUNT - 1) / NODE_COUNT);

        logic [QP_W-1:0]         quo_prod;
        logic [NODE_INDEX_W-1:0] quo_reg;
        logic [BP_W-1:0]         back_prod;
        logic [NODE_INDEX_W-1:0] rem;

        assign quo_prod = QP_W'(in_ch.node_index) * QP_W'(MUL);

        always_ff @(posedge clk)
        begin
            if (take)
            begin
                quo_reg <= quo_prod[SHIFT +: NODE_INDEX_W];
            end
        end

        assign back_prod = BP_W'(quo_reg) * BP_W'(NODE_COUNT);
        assign rem = f_item_reg.node_index - back_prod[NODE_INDEX_W-1:0];
        assign f_key = rem[KEY_W-1:0];
    end

    // same node still in flight: hold until its state is written back
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < HAZ_N; i++)
        begin
            if (busy_valid[i] && (busy_key[i] == f_key))
            begin
                hit = 1'b1;
            end
        end
    end

    assign push = f_valid_reg && !hit && !queue_full;
    assign push_item = f_item_reg;
    assign push_key = f_key;
    assign in_ch.ready = (!f_valid_reg || push) && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            f_valid_reg <= in_ch.valid;
        end
        else if (push)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_item_reg <= '{node_index: in_ch.node_index, drive_sample: in_ch.drive_sample};
        end
    end

endmodule

// ===== rtl/dons_queue.sv =====
module dons_queue import dons_pkg::*; #(
    parameter int KEY_W = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  item_t                             push_item,
    input  logic [KEY_W-1:0]                  push_key,
    output logic                              full,
    input  logic                              pop,
    output logic                              head_valid,
    output item_t                             head_item,
    output logic [KEY_W-1:0]                  head_key,
    output logic [QUEUE_DEPTH-1:0]            busy_valid,
    output logic [QUEUE_DEPTH-1:0][KEY_W-1:0] busy_key
);

    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_DEPTH-1:0] slot_valid_reg;
    logic [QUEUE_DEPTH-1:0] slot_valid_next;
    item_t                  slot_item_reg [QUEUE_DEPTH];
    logic [KEY_W-1:0]       slot_key_reg [QUEUE_DEPTH];

    assign full = slot_valid_reg[wr_ptr_reg];
    assign head_valid = slot_valid_reg[rd_ptr_reg];
    assign head_item = slot_item_reg[rd_ptr_reg];
    assign head_key = slot_key_reg[rd_ptr_reg];
    assign busy_valid = slot_valid_reg;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            busy_key[i] = slot_key_reg[i];
        end
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (push && !full)
        begin
            slot_valid_next[wr_ptr_reg] = 1'b1;
        end
        if (pop && head_valid)
        begin
            slot_valid_next[rd_ptr_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            slot_valid_reg <= '0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_item_reg[wr_ptr_reg] <= push_item;
            slot_key_reg[wr_ptr_reg] <= push_key;
        end
    end

endmodule

// ===== rtl/dons_back.sv =====
module dons_back import dons_pkg::*; #(
    parameter int NODE_COUNT = 1024,
    parameter int FRACTION_BITS = 16,
    parameter int KEY_W = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dons_out_if.source                        out_ch,
    input  osc_cfg_t                          cfg,
    input  logic signed [DATA_W-1:0]          level,
    input  logic                              level_load,
    input  logic                              head_valid,
    input  item_t                             head_item,
    input  logic [KEY_W-1:0]                  head_key,
    output logic                              pop,
    output logic                              hold,
    output logic [BACK_STAGES-1:0]            busy_valid,
    output logic [BACK_STAGES-1:0][KEY_W-1:0] busy_key
);

    localparam int NST = BACK_STAGES;
    localparam int unsigned FB = FRACTION_BITS;
    localparam int STATE_W = $bits(node_state_t);
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NODE_COUNT - 1);

    logic adv;

    logic                     v_reg    [1:NST];
    logic [NODE_INDEX_W-1:0]  node_reg [1:NST];
    logic [KEY_W-1:0]         key_reg  [1:NST];
    logic signed [DATA_W-1:0] q_reg    [1:NST];
    logic signed [DATA_W-1:0] ld_reg   [2:5];
    logic signed [DATA_W-1:0] lp_reg   [2:6];
    logic signed [DATA_W-1:0] pr_reg   [2:8];
    logic signed [DATA_W-1:0] r_reg    [4:NST];
    logic signed [DATA_W-1:0] tail_reg [6:14];
    logic signed [DATA_W-1:0] a_reg    [7:11];
    logic signed [DATA_W-1:0] c_reg    [10:13];

    logic signed [DATA_W-1:0] dq2_reg, dq2_next;
    logic signed [63:0]       p3_reg, p3_next;
    logic signed [DATA_W-1:0] r4_next;
    logic signed [63:0]       p5_reg, p5_next;
    logic signed [DATA_W-1:0] tail6_next;
    logic signed [DATA_W-1:0] u6_reg, u6_next;
    logic signed [DATA_W-1:0] a7_next;
    logic signed [63:0]       p8_reg, p8_next;
    logic signed [DATA_W-1:0] v9_reg, v9_next;
    logic signed [DATA_W-1:0] c10_next;
    logic signed [63:0]       p11_reg, p11_next;
    logic signed [DATA_W-1:0] d12_reg, d12_next;
    logic signed [63:0]       pdk13_reg, pdk13_next;
    logic signed [63:0]       pgd13_reg, pgd13_next;
    logic signed [DATA_W-1:0] w14_reg, w14_next;
    logic signed [DATA_W-1:0] e14_reg, e14_next;
    logic signed [DATA_W-1:0] phi15_reg, phi15_next;
    logic signed [63:0]       pek15_reg, pek15_next;
    logic signed [DATA_W-1:0] rate_next;

    logic signed [DATA_W-1:0] damp_s, step_s, inv_s, tod_s, decay_s;

    logic                     out_valid_reg;
    logic [NODE_INDEX_W-1:0]  out_node_reg;
    logic signed [DATA_W-1:0] out_phi_reg;

    logic             clear_reg;
    logic [KEY_W-1:0] clear_addr_reg;

    logic               ram_we;
    logic [KEY_W-1:0]   ram_waddr;
    logic [STATE_W-1:0] ram_wdata;
    logic [STATE_W-1:0] ram_rdata;
    node_state_t        rd_state;
    node_state_t        wr_state;

    assign adv = !out_valid_reg || out_ch.ready;
    assign pop = adv && head_valid && !clear_reg;
    assign hold = clear_reg;

    assign damp_s  = $signed({1'b0, cfg.damping_rate});
    assign step_s  = $signed({1'b0, cfg.step_length});
    assign inv_s   = $signed({1'b0, cfg.inverse_step});
    assign tod_s   = $signed({1'b0, cfg.two_over_damping});
    assign decay_s = $signed({{(DATA_W-DECAY_W){1'b0}}, cfg.decay_factor});

    assign rd_state = ram_rdata;

    always_comb
    begin
        dq2_next   = sub_s(q_reg[1], rd_state.last_drive);
        p3_next    = dq2_reg * inv_s;
        r4_next    = fx_scale(p3_reg, FB);
        p5_next    = tod_s * r_reg[4];
        tail6_next = fx_scale(p5_reg, FB);
        u6_next    = sub_s(ld_reg[5], tail6_next);
        a7_next    = sub_s(u6_reg, lp_reg[6]);
        p8_next    = damp_s * a_reg[7];
        v9_next    = sub_s(pr_reg[8], fx_scale(p8_reg, FB));
        c10_next   = sub_s(v9_reg, r_reg[9]);
        p11_next   = c_reg[10] * step_s;
        d12_next   = sub_s(fx_scale(p11_reg, FB), a_reg[11]);
        pdk13_next = d12_reg * decay_s;
        pgd13_next = damp_s * d12_reg;
        w14_next   = add_s(fx_scale(pdk13_reg, FB), q_reg[13]);
        e14_next   = sub_s(c_reg[13], fx_scale(pgd13_reg, FB));
        phi15_next = sub_s(w14_reg, tail_reg[14]);
        pek15_next = e14_reg * decay_s;
        rate_next  = add_s(fx_scale(pek15_reg, FB), r_reg[NST]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= NST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[1] <= pop;
            for (int i = 2; i <= NST; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            out_valid_reg <= v_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            node_reg[1] <= head_item.node_index;
            key_reg[1] <= head_key;
            q_reg[1] <= head_item.drive_sample;
            for (int i = 2; i <= NST; i++)
            begin
                node_reg[i] <= node_reg[i-1];
                key_reg[i] <= key_reg[i-1];
                q_reg[i] <= q_reg[i-1];
            end

            ld_reg[2] <= rd_state.last_drive;
            lp_reg[2] <= rd_state.last_phi;
            pr_reg[2] <= rd_state.phi_rate;
            for (int i = 3; i <= 5; i++)
            begin
                ld_reg[i] <= ld_reg[i-1];
            end
            for (int i = 3; i <= 6; i++)
            begin
                lp_reg[i] <= lp_reg[i-1];
            end
            for (int i = 3; i <= 8; i++)
            begin
                pr_reg[i] <= pr_reg[i-1];
            end

            r_reg[4] <= r4_next;
            for (int i = 5; i <= NST; i++)
            begin
                r_reg[i] <= r_reg[i-1];
            end
            tail_reg[6] <= tail6_next;
            for (int i = 7; i <= 14; i++)
            begin
                tail_reg[i] <= tail_reg[i-1];
            end
            a_reg[7] <= a7_next;
            for (int i = 8; i <= 11; i++)
            begin
                a_reg[i] <= a_reg[i-1];
            end
            c_reg[10] <= c10_next;
            for (int i = 11; i <= 13; i++)
            begin
                c_reg[i] <= c_reg[i-1];
            end

            dq2_reg   <= dq2_next;
            p3_reg    <= p3_next;
            p5_reg    <= p5_next;
            u6_reg    <= u6_next;
            p8_reg    <= p8_next;
            v9_reg    <= v9_next;
            p11_reg   <= p11_next;
            d12_reg   <= d12_next;
            pdk13_reg <= pdk13_next;
            pgd13_reg <= pgd13_next;
            w14_reg   <= w14_next;
            e14_reg   <= e14_next;
            phi15_reg <= phi15_next;
            pek15_reg <= pek15_next;

            if (v_reg[NST])
            begin
                out_node_reg <= node_reg[NST];
                out_phi_reg <= phi15_reg;
            end
        end
    end

    // sweep loading the start level into every node
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (level_load)
        begin
            clear_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_KEY)
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clear_reg)
        begin
            wr_state = '{last_drive: level, last_phi: level, phi_rate: '0};
            ram_waddr = clear_addr_reg;
        end
        else
        begin
            wr_state = '{last_drive: q_reg[NST], last_phi: phi15_reg, phi_rate: rate_next};
            ram_waddr = key_reg[NST];
        end
    end

    assign ram_we = clear_reg || (adv && v_reg[NST]);
    assign ram_wdata = wr_state;

    dons_ram #(
        .WIDTH(STATE_W),
        .DEPTH(NODE_COUNT),
        .ADDR_W(KEY_W)
    ) u_state_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re(pop),
        .raddr(head_key),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            busy_valid[i] = v_reg[i+1];
            busy_key[i] = key_reg[i+1];
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.node_out = out_node_reg;
    assign out_ch.phi_out = out_phi_reg;

endmodule

// ===== rtl/damped_oscillator_node_step.sv =====
// Channel   Dir   Handshake      Payload
// in_ch     in    valid/ready    node_index[9:0], drive_sample[31:0] signed
// out_ch    out   valid/ready    node_out[9:0], phi_out[31:0] signed
// cfg       in    cfg_we         cfg_index[2:0], cfg_data[31:0]
//
// One item per cycle while no item in flight names the same node and the output does not stall.
// An item whose node is still in the 15 stage back pipeline or queue waits in the
// front stage until that node's state is written back.
// After reset and after each initial_level write, a sweep loads every node of
// the state memory; in_ch.ready stays low meanwhile.
// Output stall holds the back pipeline; the queue and front stage keep taking items until the queue is full.
module damped_oscillator_node_step import dons_pkg::*; #(
    parameter int NODE_COUNT = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    dons_in_if.sink                in_ch,
    dons_out_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

    localparam int KEY_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int HAZ_N = BACK_STAGES + QUEUE_DEPTH;

    osc_cfg_t                 cfg_reg;
    logic signed [DATA_W-1:0] level_reg;
    logic                     level_load;

    logic                              q_push;
    item_t                             q_push_item;
    logic [KEY_W-1:0]                  q_push_key;
    logic                              q_full;
    logic                              q_pop;
    logic                              q_head_valid;
    item_t                             q_head_item;
    logic [KEY_W-1:0]                  q_head_key;
    logic [QUEUE_DEPTH-1:0]            q_busy_valid;
    logic [QUEUE_DEPTH-1:0][KEY_W-1:0] q_busy_key;
    logic [BACK_STAGES-1:0]            b_busy_valid;
    logic [BACK_STAGES-1:0][KEY_W-1:0] b_busy_key;
    logic [HAZ_N-1:0]                  haz_valid;
    logic [HAZ_N-1:0][KEY_W-1:0]       haz_key;
    logic                              hold;

    assign level_load = cfg_we && (cfg_index == REG_INITIAL_LEVEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
            level_reg <= LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DAMPING_RATE:     cfg_reg.damping_rate <= cfg_data[RATE_W-1:0];
                REG_STEP_LENGTH:      cfg_reg.step_length <= cfg_data[RATE_W-1:0];
                REG_INVERSE_STEP:     cfg_reg.inverse_step <= cfg_data[RATE_W-1:0];
                REG_TWO_OVER_DAMPING: cfg_reg.two_over_damping <= cfg_data[RATE_W-1:0];
                REG_DECAY_FACTOR:     cfg_reg.decay_factor <= cfg_data[DECAY_W-1:0];
                REG_INITIAL_LEVEL:    level_reg <= $signed(cfg_data);
                default:              ;
            endcase
        end
    end

    assign haz_valid = {b_busy_valid, q_busy_valid};
    assign haz_key = {b_busy_key, q_busy_key};

    dons_front #(
        .NODE_COUNT(NODE_COUNT),
        .KEY_W(KEY_W),
        .HAZ_N(HAZ_N)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .hold(hold),
        .busy_valid(haz_valid),
        .busy_key(haz_key),
        .queue_full(q_full),
        .push(q_push),
        .push_item(q_push_item),
        .push_key(q_push_key)
    );

    dons_queue #(
        .KEY_W(KEY_W)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_item(q_push_item),
        .push_key(q_push_key),
        .full(q_full),
        .pop(q_pop),
        .head_valid(q_head_valid),
        .head_item(q_head_item),
        .head_key(q_head_key),
        .busy_valid(q_busy_valid),
        .busy_key(q_busy_key)
    );

    dons_back #(
        .NODE_COUNT(NODE_COUNT),
        .FRACTION_BITS(FRACTION_BITS),
        .KEY_W(KEY_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .out_ch(out_ch),
        .cfg(cfg_reg),
        .level(level_reg),
        .level_load(level_load),
        .head_valid(q_head_valid),
        .head_item(q_head_item),
        .head_key(q_head_key),
        .pop(q_pop),
        .hold(hold),
        .busy_valid(b_busy_valid),
        .busy_key(b_busy_key)
    );

endmodule
